FILE: src/bilf_pkg.sv
// ----------------------------------------------------------------------------
// bilf_pkg
// Shared types, constants and helpers of the 8-bit bilateral filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bilf_pkg;

	localparam int MAX_RADIUS    = 4;
	localparam int MAX_WIDTH     = 2048;
	localparam int MAX_HEIGHT    = 2048;
	localparam int RANGE_LEVELS  = 256;

	localparam int KSIDE         = 2 * MAX_RADIUS + 1;
	localparam int SPATIAL_DEPTH = KSIDE * KSIDE;
	localparam int STORE_DEPTH   = MAX_WIDTH * KSIDE;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int KS_W    = $clog2(KSIDE);
	localparam int STORE_AW = COL_W + KS_W;
	localparam int SIDX_W  = $clog2(SPATIAL_DEPTH);
	localparam int ITEM_W  = 23;
	localparam int HI_W    = ITEM_W - COL_W;
	localparam int RECIP_SH = 16;
	localparam int RECIP   = ((1 << RECIP_SH) + KSIDE - 1) / KSIDE;

	localparam logic [1:0] MODE_PIXEL   = 2'd0;
	localparam logic [1:0] MODE_FLUSH   = 2'd1;
	localparam logic [1:0] MODE_SPATIAL = 2'd2;
	localparam logic [1:0] MODE_RANGE   = 2'd3;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] pixel;
		logic [7:0] table_index;
		logic [8:0] table_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  filtered_pixel;
		logic [10:0] out_column;
		logic [10:0] out_row;
		logic        frame_last;
	} out_item_t;

	// Position modulo the store depth. The depth is a power of two times the
	// kernel side, so only the upper part needs a remainder, taken through a
	// reciprocal multiply that is exact over the upper part's range.
	function automatic logic [STORE_AW-1:0] addr_mod(input logic [ITEM_W-1:0] x);
		logic [HI_W-1:0]          hi;
		logic [HI_W+RECIP_SH-1:0] prod;
		logic [HI_W-1:0]          quot;
		logic [HI_W-1:0]          rem;
		hi   = x[ITEM_W-1:COL_W];
		prod = (HI_W+RECIP_SH)'(hi) * (HI_W+RECIP_SH)'(RECIP);
		quot = HI_W'(prod >> RECIP_SH);
		rem  = hi - HI_W'(quot * HI_W'(KSIDE));
		return {rem[KS_W-1:0], x[COL_W-1:0]};
	endfunction

endpackage

`default_nettype wire

FILE: src/bilateral_filter_8bit.sv
// ----------------------------------------------------------------------------
// bilateral_filter_8bit
// Streaming bilateral filter for one 8-bit plane with loadable weight tables.
// ----------------------------------------------------------------------------
// Items enter on the pix channel (valid/ready). Mode pixel and flush items
// advance the frame; load items write the spatial or range weight table in
// the cycle of their transfer and give no result. A filtered pixel leaves on
// the res channel r rows plus r pixels after its own input item.
// A pixel or flush item that gives no result passes only the start and
// write steps; one that gives a result then finds its row and column, walks
// the window one tap a cycle through a four-stage multiply-accumulate and
// emits a result. A shared restoring divider takes one quotient bit per
// cycle, first for the row and column of the output, then for the weighted
// mean. No new item is taken until the last one is done.
// The finished result sits in an output register; if the receiver stalls,
// the next result waits in its last step until that register frees up.
// Reset clears the frame counter, the sequencer and the output valid, and
// restores the default geometry (720 x 576, radius 2). The row store and the
// weight tables hold nothing defined until written.
// Configuration is a plain write port, to be used only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module bilateral_filter_8bit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   pix_valid,
	output logic                  pix_ready,
	input  bilf_pkg::in_item_t    pix_data,
	output logic                  res_valid,
	input  wire                   res_ready,
	output bilf_pkg::out_item_t   res_data,
	input  wire                   cfg_we,
	input  wire  [1:0]            cfg_index,
	input  wire  [11:0]           cfg_data
);
	import bilf_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_WRITE = 4'd2;
	localparam logic [3:0] ST_DIVQ  = 4'd3;
	localparam logic [3:0] ST_BASE  = 4'd4;
	localparam logic [3:0] ST_CTR   = 4'd5;
	localparam logic [3:0] ST_LOOP  = 4'd6;
	localparam logic [3:0] ST_DRAIN = 4'd7;
	localparam logic [3:0] ST_DIVS  = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0] state_q;

	// Configuration and derived geometry.
	logic [11:0] width_q, height_q;
	logic [2:0]  radius_q;
	logic [11:0] w_eff, h_eff;
	logic [2:0]  r_eff;
	logic [11:0] w_q, h_q;
	logic [2:0]  r_q;
	logic [ITEM_W-1:0] total_q, lag_q, last_q;

	always_comb begin
		if (width_q == 12'd0) w_eff = 12'd1;
		else if (width_q > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == 12'd0) h_eff = 12'd1;
		else if (height_q > 12'(MAX_HEIGHT)) h_eff = 12'(MAX_HEIGHT);
		else h_eff = height_q;
		r_eff = (radius_q > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd720;
			height_q <= 12'd576;
			radius_q <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		w_q     <= w_eff;
		h_q     <= h_eff;
		r_q     <= r_eff;
		total_q <= ITEM_W'(24'(w_eff) * 24'(h_eff));
		lag_q   <= ITEM_W'(15'(r_eff) * 15'(w_eff)) + ITEM_W'(r_eff);
	end

	// Item and window bookkeeping.
	logic [ITEM_W-1:0] items_seen_q, t_q, q_q;
	logic [7:0]        pixel_q, centre_q;
	logic [10:0]       row_q, col_q;
	logic              last_px_q;
	logic signed [12:0] nr_q, nc_q;
	logic signed [23:0] pos_q;
	logic [3:0]         ix_q, iy_q;
	logic [SIDX_W-1:0]  sidx_q;
	logic [3:0]         two_r;
	logic [3:0]         side;
	logic               in_frame;
	logic               tap_end;

	assign two_r = {r_q, 1'b0};
	assign side  = two_r + 4'd1;
	assign in_frame = (nr_q >= 13'sd0) && (nc_q >= 13'sd0) &&
		(nr_q < $signed({1'b0, h_q})) && (nc_q < $signed({1'b0, w_q}));
	assign tap_end = (ix_q == two_r) && (iy_q == two_r);

	// Shared restoring divider, one quotient bit per cycle.
	logic [30:0] rem_q;
	logic [22:0] den_q;
	logic [10:0] quo_q;
	logic [3:0]  cnt_q;
	logic [33:0] shifted;
	logic        ge;
	logic [30:0] rem_next;
	logic [10:0] quo_next;

	assign shifted  = 34'(den_q) << cnt_q;
	assign ge       = 34'(rem_q) >= shifted;
	assign rem_next = ge ? (rem_q - shifted[30:0]) : rem_q;
	assign quo_next = {quo_q[9:0], ge};

	// Row store.
	logic [7:0]          store_mem [STORE_DEPTH];
	logic                st_we, st_re;
	logic [STORE_AW-1:0] st_waddr, st_raddr;
	logic [7:0]          rd_q;

	assign st_we    = (state_q == ST_WRITE) && (t_q < total_q);
	assign st_waddr = addr_mod(t_q);
	assign st_re    = (state_q == ST_BASE) || ((state_q == ST_LOOP) && in_frame);
	assign st_raddr = (state_q == ST_BASE) ? addr_mod(q_q) : addr_mod(pos_q[ITEM_W-1:0]);

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_waddr] <= pixel_q;
		if (st_re) rd_q <= store_mem[st_raddr];
	end

	// Weight tables.
	logic [8:0] spatial_mem [SPATIAL_DEPTH];
	logic [8:0] range_mem [RANGE_LEVELS];
	logic       pix_xfer;

	assign pix_ready = (state_q == ST_IDLE);
	assign pix_xfer  = pix_valid && pix_ready;

	// Multiply-accumulate pipeline over the window taps.
	logic              v_s1, v_s2, v_s3;
	logic              in_s1, in_s2, in_s3;
	logic [SIDX_W-1:0] sidx_s1;
	logic [7:0]        diff_s1;
	logic [8:0]        sw_s2, rw_s2;
	logic [7:0]        pix_s2, pix_s3;
	logic [17:0]       weight_s3;
	logic [30:0]       sum_q;
	logic [22:0]       wsum_q;

	assign diff_s1 = (rd_q > centre_q) ? (rd_q - centre_q) : (centre_q - rd_q);

	always_ff @(posedge clk) begin
		if (pix_xfer && (pix_data.mode == MODE_SPATIAL) &&
			(pix_data.table_index < 8'(SPATIAL_DEPTH))) begin
			spatial_mem[pix_data.table_index[SIDX_W-1:0]] <= pix_data.table_value;
		end
		sw_s2 <= spatial_mem[sidx_s1];
	end

	always_ff @(posedge clk) begin
		if (pix_xfer && (pix_data.mode == MODE_RANGE)) begin
			range_mem[pix_data.table_index] <= pix_data.table_value;
		end
		rw_s2 <= range_mem[diff_s1];
	end

	always_ff @(posedge clk) begin
		sidx_s1   <= sidx_q;
		in_s1     <= in_frame;
		pix_s2    <= rd_q;
		in_s2     <= in_s1;
		weight_s3 <= 18'(sw_s2) * 18'(rw_s2);
		pix_s3    <= pix_s2;
		in_s3     <= in_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_LOOP);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Sequencer.
	logic [7:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			items_seen_q <= '0;
			res_valid    <= 1'b0;
		end else begin
			if (res_valid && res_ready && (state_q != ST_EMIT)) res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pix_xfer && ((pix_data.mode == MODE_PIXEL) ||
						(pix_data.mode == MODE_FLUSH))) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WRITE;
					if (items_seen_q > last_q) items_seen_q <= '0;
				end
				ST_WRITE: begin
					items_seen_q <= (t_q == last_q) ? '0 : t_q + ITEM_W'(1);
					state_q <= (t_q >= lag_q) ? ST_DIVQ : ST_IDLE;
				end
				ST_DIVQ: begin
					if (cnt_q == 4'd0) state_q <= ST_BASE;
				end
				ST_BASE:  state_q <= ST_CTR;
				ST_CTR:   state_q <= ST_LOOP;
				ST_LOOP: begin
					if (tap_end) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= (wsum_q == '0) ? ST_EMIT : ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (cnt_q == 4'd0) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!res_valid || res_ready) begin
						res_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				pixel_q <= pix_data.pixel;
			end
			ST_START: begin
				last_q <= total_q + lag_q - ITEM_W'(1);
				t_q    <= (items_seen_q > (total_q + lag_q - ITEM_W'(1))) ? '0 : items_seen_q;
			end
			ST_WRITE: begin
				q_q   <= t_q - lag_q;
				rem_q <= 31'(t_q - lag_q);
				den_q <= 23'(w_q);
				quo_q <= '0;
				cnt_q <= 4'd10;
			end
			ST_DIVQ: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					row_q <= quo_next;
					col_q <= rem_next[10:0];
				end
			end
			ST_BASE: begin
				nr_q      <= $signed({2'b00, row_q}) - $signed({10'd0, r_q});
				nc_q      <= $signed({2'b00, col_q}) - $signed({10'd0, r_q});
				pos_q     <= $signed({1'b0, q_q}) - $signed({1'b0, lag_q});
				ix_q      <= '0;
				iy_q      <= '0;
				sidx_q    <= SIDX_W'(side) * SIDX_W'(side) - SIDX_W'(1);
				last_px_q <= (q_q == total_q - ITEM_W'(1));
				sum_q     <= '0;
				wsum_q    <= '0;
			end
			ST_CTR: begin
				centre_q <= rd_q;
			end
			ST_LOOP: begin
				sidx_q <= sidx_q - SIDX_W'(1);
				if (ix_q == two_r) begin
					ix_q  <= '0;
					iy_q  <= iy_q + 4'd1;
					nr_q  <= nr_q + 13'sd1;
					nc_q  <= $signed({2'b00, col_q}) - $signed({10'd0, r_q});
					pos_q <= pos_q + $signed({12'd0, w_q}) - $signed({20'd0, two_r});
				end else begin
					ix_q  <= ix_q + 4'd1;
					nc_q  <= nc_q + 13'sd1;
					pos_q <= pos_q + 24'sd1;
				end
			end
			ST_DRAIN: begin
				rem_q    <= sum_q;
				den_q    <= wsum_q;
				quo_q    <= '0;
				cnt_q    <= 4'd7;
				result_q <= centre_q;
			end
			ST_DIVS: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) result_q <= quo_next[7:0];
			end
			ST_EMIT: begin
				if (!res_valid || res_ready) begin
					res_data.filtered_pixel <= result_q;
					res_data.out_column     <= col_q;
					res_data.out_row        <= row_q;
					res_data.frame_last     <= last_px_q;
				end
			end
			default: ;
		endcase
		// The last stage of the tap pipeline accumulates while the walk and its drain run.
		if (v_s3 && in_s3) begin
			sum_q  <= sum_q + 31'(26'(weight_s3) * 26'(pix_s3));
			wsum_q <= wsum_q + 23'(weight_s3);
		end
	end

	// The row store port is never asked to write and read at once.
	assert property (@(posedge clk) disable iff (!arst_n) !(st_we && st_re))
		else $error("row store write and read in the same cycle");

	// Taps are in flight only during the window walk and its drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOOP && state_q != ST_DRAIN) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("tap pipeline busy outside the window walk");

	// In both divisions, the divider step counter stays within the quotient width of the row division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVQ || state_q == ST_DIVS) |-> (cnt_q <= 4'd10))
		else $error("divider step count out of range");

	// A new item is taken only when no tap is left from the previous one.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("input taken while taps are in flight");

endmodule

`default_nettype wire
